// ===== sv/modbus_fc16_frame_generator_core_macros.svh =====
// Assertion macros used by the checker file of the frame generator.
`ifndef MODBUS_FC16_FRAME_GENERATOR_CORE_MACROS_SVH
`define MODBUS_FC16_FRAME_GENERATOR_CORE_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define MBFC16_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define MBFC16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/mbfc16_pkg.sv =====
package mbfc16_pkg;

    // Frame layout constants.
    localparam logic [3:0]  FRAME_LAST_IDX = 4'd12;
    localparam logic [3:0]  CRC_LAST_IDX   = 4'd10;
    localparam logic [7:0]  QTY_HI         = 8'h00;
    localparam logic [7:0]  QTY_LO         = 8'h02;
    localparam logic [7:0]  DATA_BYTE_CNT  = 8'h04;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
    localparam logic [7:0]  FUNC_CODE_RST  = 8'd16;
    localparam logic [15:0] START_REG_RST  = 16'd0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SLAVE_ADDR = 2'd0,
        REG_FUNC_CODE  = 2'd1,
        REG_START_REG  = 2'd2
    } t_reg_idx;

    // Current configuration, handed from the register file to the framer.
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] start_register;
    } t_cfg;

    // One byte step of CRC-16/Modbus, reflected form.
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/mbfc16_cfg_regs.sv =====
module mbfc16_cfg_regs
    import mbfc16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register file; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= SLAVE_ADDR_RST;
            r_cfg.function_code  <= FUNC_CODE_RST;
            r_cfg.start_register <= START_REG_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_SLAVE_ADDR: r_cfg.slave_address  <= i_wr_data[7:0];
                REG_FUNC_CODE:  r_cfg.function_code  <= i_wr_data[7:0];
                REG_START_REG:  r_cfg.start_register <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/mbfc16_framer.sv =====
module mbfc16_framer
    import mbfc16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    input  logic [31:0] i_value_bits,
    output logic        o_busy,
    output logic        o_valid,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    // Input holding register.
    logic        r_pend_valid;
    logic [31:0] r_pend_word;

    // Frame sequencer.
    logic        r_active;
    logic [3:0]  r_idx;
    logic [31:0] r_word;
    logic [15:0] r_crc;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        accept;
    logic        frame_end;
    logic        load;
    logic [7:0]  cur_byte;
    logic [15:0] n_crc;

    assign accept    = i_start && !r_pend_valid;
    assign frame_end = r_active && (r_idx == FRAME_LAST_IDX);
    assign load      = r_pend_valid && (!r_active || frame_end);

    // Select the frame byte for the current position.
    always_comb begin
        case (r_idx)
            4'd0:    cur_byte = i_cfg.slave_address;
            4'd1:    cur_byte = i_cfg.function_code;
            4'd2:    cur_byte = i_cfg.start_register[15:8];
            4'd3:    cur_byte = i_cfg.start_register[7:0];
            4'd4:    cur_byte = QTY_HI;
            4'd5:    cur_byte = QTY_LO;
            4'd6:    cur_byte = DATA_BYTE_CNT;
            4'd7:    cur_byte = r_word[31:24];
            4'd8:    cur_byte = r_word[23:16];
            4'd9:    cur_byte = r_word[15:8];
            4'd10:   cur_byte = r_word[7:0];
            4'd11:   cur_byte = r_crc[7:0];
            4'd12:   cur_byte = r_crc[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    // The CRC folds in one byte per cycle over the header and payload.
    assign n_crc = (r_idx <= CRC_LAST_IDX) ? crc_add_byte(r_crc, cur_byte) : r_crc;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_active     <= 1'b0;
            r_idx        <= 4'd0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_valid <= 1'b1;
            end else if (load) begin
                r_pend_valid <= 1'b0;
            end

            if (load) begin
                r_active <= 1'b1;
                r_idx    <= 4'd0;
            end else if (frame_end) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_idx <= r_idx + 4'd1;
            end

            r_out_valid <= r_active;
            r_out_last  <= frame_end;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_word <= i_value_bits;
        end
        if (load) begin
            r_word <= r_pend_word;
            r_crc  <= CRC_INIT;
        end else if (r_active) begin
            r_crc <= n_crc;
        end
        r_out_byte <= cur_byte;
    end

    assign o_busy       = r_pend_valid;
    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

// ===== sv/modbus_fc16_frame_generator_core.sv =====
// Modbus RTU write-multiple-registers request generator.
// Command channel: a 32-bit word on i_value_bits is taken at a clock edge
// where i_start is high and o_busy is low. Each word yields a 13-byte frame:
// address, function code, start register, quantity 2, byte count 4, the word
// big-endian, then the CRC-16/Modbus low byte and high byte.
// Result channel: o_valid strobes each byte on o_frame_byte for one cycle;
// o_last_byte marks the CRC high byte. The receiver cannot stall, so bytes
// leave at one per cycle with no gaps inside a frame.
// The word passes from the input holding register to the frame sequencer;
// bytes leave through the result register. Frame rate is set by the output
// and the CRC, each one byte per cycle. A one-word input register takes the
// next word while a frame is going out, so frames run back to back.
// Configuration: index 0 slave address, 1 function code, 2 start register,
// written through i_cfg_valid/o_cfg_ready; other indexes are ignored. Write
// only while no frame is pending or in flight.
// Reset (synchronous, active low) drops any pending word and frame in flight
// and restores address 1, function code 16, start register 0.
module modbus_fc16_frame_generator_core
    import mbfc16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value_bits,
    output logic        o_busy,
    output logic        o_valid,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg cfg;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    mbfc16_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    mbfc16_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_start      (i_start),
        .i_value_bits (i_value_bits),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

// ===== sv/mbfc16_checker.sv =====
`include "modbus_fc16_frame_generator_core_macros.svh"

module mbfc16_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_last_byte
);

    // An accepted word occupies the input register in the cycle after it is taken.
    `MBFC16_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

    // The end-of-frame flag only rides on a strobed byte.
    `MBFC16_ASSERT(a_last_valid, i_clk, i_rst_n, !o_last_byte || o_valid)

    // Frames are 13 bytes, so two end flags never sit next to each other.
    `MBFC16_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_last_byte, !o_last_byte)

    // An end flag implies a strobed byte where the frame's first byte went out.
    `MBFC16_ASSERT(a_frame_run, i_clk, i_rst_n, !o_last_byte || $past(o_valid, 12))

endmodule

bind modbus_fc16_frame_generator_core mbfc16_checker u_mbfc16_checker (.*);

// ===== dv/modbus_fc16_frame_generator_core_test.sv =====
`timescale 1ns / 100ps

module modbus_fc16_frame_generator_core_test;
    import mbfc16_pkg::*;

    // Frame layout as the protocol defines it, kept apart from the design's package.
    localparam logic [15:0] FCS_SEED    = 16'hFFFF;
    localparam logic [15:0] FCS_POLY    = 16'hA001;
    localparam logic [15:0] FRAME_QTY   = 16'd2;
    localparam logic [7:0]  FRAME_BCNT  = 8'd4;
    localparam int          FRAME_LEN   = 13;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;
    localparam int          IDLE_PAUSE  = 4;
    localparam int          DRAIN_WAIT  = 20;
    localparam int          PHASES      = 6;
    localparam int          PHASE_WORDS = 50;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // One row of the directed table: either a register write or a payload word.
    // When hdr_given is set, the header bytes are typed in the row itself.
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  cfg_index;
        logic [15:0] cfg_data;
        logic [31:0] word;
        bit          hdr_given;
        t_cfg        hdr;
    } t_stim_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_fc16_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [31:0] i_value_bits;
    logic        o_busy;
    logic        o_valid;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    t_cfg        cfg_shadow;
    t_fc16_byte  tx_byte_q[$];
    t_stim_row   dir_rows[$];
    int          mismatch_cnt;
    bit          no_idle;

    modbus_fc16_frame_generator_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_value_bits (i_value_bits),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Serial CRC-16/Modbus: data enters least significant bit first.
    function automatic logic [15:0] fcs_fold_byte(input logic [15:0] fcs,
                                                  input logic [7:0]  data);
        logic [15:0] acc;
        logic        fb;
        int          b;
        acc = fcs;
        for (b = 0; b < 8; b++) begin
            fb  = acc[0] ^ data[b];
            acc = {1'b0, acc[15:1]};
            if (fb) begin
                acc = acc ^ FCS_POLY;
            end
        end
        return acc;
    endfunction

    // Build the 13-byte request for one word and queue it for the checker.
    task automatic predict_frame(input t_cfg cfg, input logic [31:0] word);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] fcs;
        t_fc16_byte  item;
        int          n;
        frame[0]  = cfg.slave_address;
        frame[1]  = cfg.function_code;
        frame[2]  = cfg.start_register[15:8];
        frame[3]  = cfg.start_register[7:0];
        frame[4]  = FRAME_QTY[15:8];
        frame[5]  = FRAME_QTY[7:0];
        frame[6]  = FRAME_BCNT;
        frame[7]  = word[31:24];
        frame[8]  = word[23:16];
        frame[9]  = word[15:8];
        frame[10] = word[7:0];
        fcs = FCS_SEED;
        for (n = 0; n < 11; n++) begin
            fcs = fcs_fold_byte(fcs, frame[n]);
        end
        frame[11] = fcs[7:0];
        frame[12] = fcs[15:8];
        for (n = 0; n < FRAME_LEN; n++) begin
            item.data = frame[n];
            item.last = (n == FRAME_LEN - 1);
            tx_byte_q.push_back(item);
        end
    endtask

    // Let every expected byte leave, then wait out the idle pause.
    task automatic wait_idle();
        while (tx_byte_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // Write one register word through the configuration channel while idle.
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_start <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SLAVE_ADDR: cfg_shadow.slave_address  = data[7:0];
            REG_FUNC_CODE:  cfg_shadow.function_code  = data[7:0];
            REG_START_REG:  cfg_shadow.start_register = data;
            default: ;
        endcase
    endtask

    // Offer one payload word after a random gap, or none when no_idle is set; start
    // stays high across back-to-back words so it is never lowered and raised in one step.
    task automatic send_word(input logic [31:0] word, input t_cfg cfg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_value_bits <= word;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_frame(cfg, word);
    endtask

    function automatic void add_word(input logic [31:0] word);
        t_stim_row r;
        r.kind      = ROW_WORD;
        r.cfg_index = '0;
        r.cfg_data  = '0;
        r.word      = word;
        r.hdr_given = 1'b0;
        r.hdr       = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_word_hdr(input logic [31:0] word, input logic [7:0] addr,
                                         input logic [7:0] func, input logic [15:0] start);
        t_stim_row r;
        r.kind      = ROW_WORD;
        r.cfg_index = '0;
        r.cfg_data  = '0;
        r.word      = word;
        r.hdr_given = 1'b1;
        r.hdr.slave_address  = addr;
        r.hdr.function_code  = func;
        r.hdr.start_register = start;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [15:0] data);
        t_stim_row r;
        r.kind      = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_data  = data;
        r.word      = '0;
        r.hdr_given = 1'b0;
        r.hdr       = '0;
        dir_rows.push_back(r);
    endfunction

    // Pick a payload: mostly random, sometimes a special float pattern.
    function automatic logic [31:0] pick_word();
        logic sign;
        sign = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0: return {sign, 31'h0};
            1: return {sign, 8'hFF, 23'h0};
            2: return {sign, 8'hFF, 23'($urandom()) | 23'h1};
            3: return {sign, 8'h00, 23'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // Result checker: every strobed byte is matched with the oldest expected byte.
    always @(posedge i_clk) begin : rx_check
        t_fc16_byte exp_byte;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (tx_byte_q.size() == 0) begin
                $error("unexpected frame byte %02h with no frame pending", o_frame_byte);
                mismatch_cnt++;
            end else begin
                exp_byte = tx_byte_q.pop_front();
                if (o_frame_byte !== exp_byte.data) begin
                    $error("frame_byte: expected %02h, actual %02h",
                           exp_byte.data, o_frame_byte);
                    mismatch_cnt++;
                end
                if (o_last_byte !== exp_byte.last) begin
                    $error("last_byte: expected %0b, actual %0b",
                           exp_byte.last, o_last_byte);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        int   ph;
        int   k;
        t_cfg row_cfg;
        mismatch_cnt = 0;
        no_idle      = 1'b0;
        cfg_shadow.slave_address  = 8'd1;
        cfg_shadow.function_code  = 8'd16;
        cfg_shadow.start_register = 16'd0;
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_value_bits <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: reset header, extremes, width truncation, unmapped index,
        // function codes other than write multiple registers.
        add_word_hdr(32'h0000_0000, 8'h01, 8'h10, 16'h0000);
        add_word_hdr(32'hFFFF_FFFF, 8'h01, 8'h10, 16'h0000);
        add_word(32'h3F80_0000);
        add_word(32'h0123_4567);
        add_cfg(REG_SLAVE_ADDR, 16'h0000);
        add_cfg(REG_FUNC_CODE, 16'h0000);
        add_cfg(REG_START_REG, 16'h0000);
        add_word_hdr(32'h0000_0000, 8'h00, 8'h00, 16'h0000);
        add_cfg(REG_SLAVE_ADDR, 16'h00FF);
        add_cfg(REG_FUNC_CODE, 16'h00FF);
        add_cfg(REG_START_REG, 16'hFFFF);
        add_word_hdr(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
        add_word(32'hAAAA_AAAA);
        add_word(32'h5555_5555);
        add_cfg(REG_SLAVE_ADDR, 16'hAB12);
        add_cfg(REG_FUNC_CODE, 16'hFF03);
        add_cfg(REG_UNMAPPED, 16'h1234);
        add_word_hdr(32'h8000_0000, 8'h12, 8'h03, 16'hFFFF);
        add_cfg(REG_START_REG, 16'h1234);
        add_word(32'h7F7F_FFFF);
        add_cfg(REG_SLAVE_ADDR, 16'h0001);
        add_cfg(REG_FUNC_CODE, 16'h0010);
        add_word(32'hC049_0FDB);
        add_word(32'h7FC0_0000);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                cfg_write(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            end else begin
                row_cfg = dir_rows[i].hdr_given ? dir_rows[i].hdr : cfg_shadow;
                send_word(dir_rows[i].word, row_cfg);
            end
        end

        // Random phases: new settings each phase, the first two at the extremes,
        // and every other phase runs words back to back.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_write(REG_START_REG, 16'h0000);
                    cfg_write(REG_SLAVE_ADDR, 16'h0000);
                    cfg_write(REG_FUNC_CODE, 16'h0000);
                end
                1: begin
                    cfg_write(REG_FUNC_CODE, 16'hFFFF);
                    cfg_write(REG_START_REG, 16'hFFFF);
                    cfg_write(REG_SLAVE_ADDR, 16'hFFFF);
                end
                default: begin
                    cfg_write(REG_SLAVE_ADDR, 16'($urandom()));
                    cfg_write(REG_UNMAPPED, 16'($urandom()));
                    cfg_write(REG_FUNC_CODE, 16'($urandom()));
                    cfg_write(REG_START_REG, 16'($urandom()));
                end
            endcase
            no_idle = ph[0];
            for (k = 0; k < PHASE_WORDS; k++) begin
                send_word(pick_word(), cfg_shadow);
            end
        end

        // Drain and watch for stray strobes.
        i_start <= 1'b0;
        while (tx_byte_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("modbus_fc16_frame_generator_core_test: PASS");
        end else begin
            $display("modbus_fc16_frame_generator_core_test: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a frame that never completes.
    initial begin
        #5_000_000;
        $display("modbus_fc16_frame_generator_core_test: FAIL");
        $finish;
    end

endmodule
